// ===== sv/mean_threshold_binarizer_macros.svh =====
// assertion macros for the mean threshold binarizer
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef MEAN_THRESHOLD_BINARIZER_MACROS_SVH
`define MEAN_THRESHOLD_BINARIZER_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define MTB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define MTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MTB_ASSERT(lbl, clk, rst, prop, msg)
`define MTB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/mtb_pkg.sv =====
// shared types, constants and microcode rom of the mean threshold binarizer
// no dependencies
package mtb_pkg;

   localparam int COUNT_BITS = 24;
   localparam int SUM_BITS   = 32;
   localparam int PIX_BITS   = 8;
   localparam int W_BITS     = 16;
   localparam int ACC_BITS   = 24;
   localparam int LUMA_LSB   = 16;
   localparam int QUO_BITS   = 8;
   localparam int DIV_BITS   = (COUNT_BITS + QUO_BITS > SUM_BITS) ?
                               (COUNT_BITS + QUO_BITS) : SUM_BITS;
   localparam int BIT_BITS   = 3;
   localparam int STEP_BITS  = 4;

   localparam logic [W_BITS-1:0] W_RED   = 16'd19595;
   localparam logic [W_BITS-1:0] W_GREEN = 16'd38470;
   localparam logic [W_BITS-1:0] W_BLUE  = 16'd7471;

   localparam logic [PIX_BITS-1:0] LEVEL_WHITE = 8'd255;
   localparam logic [PIX_BITS-1:0] LEVEL_BLACK = 8'd0;

   typedef struct packed {
      logic                action;
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
      logic                last_pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] bw_pixel;
      logic [PIX_BITS-1:0] gray_level;
      logic                last_out;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CAPTURE,
      OP_MUL_R,
      OP_MUL_G,
      OP_MUL_B,
      OP_ACCUM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_FINISH,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_CLASSIFY,
      COND_NOT_LAST,
      COND_DIV_SKIP,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef logic [STEP_BITS-1:0] step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic classify;
      logic not_last;
      logic div_skip;
      logic div_more;
      logic out_busy;
   } stat_type;

   localparam step_type STEP_FETCH    = 4'd0;
   localparam step_type STEP_MUL_R    = 4'd1;
   localparam step_type STEP_MUL_G    = 4'd2;
   localparam step_type STEP_MUL_B    = 4'd3;
   localparam step_type STEP_BRANCH   = 4'd4;
   localparam step_type STEP_ACCUM    = 4'd5;
   localparam step_type STEP_DIV_INIT = 4'd6;
   localparam step_type STEP_DIV_STEP = 4'd7;
   localparam step_type STEP_FINISH   = 4'd8;
   localparam step_type STEP_EMIT     = 4'd9;
   localparam step_type STEP_RETURN   = 4'd10;

   // control word: run op, then jump to target if cond holds, else fall through
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      case (step)
         STEP_FETCH:    word = '{OP_CAPTURE,  COND_NO_REQ,   STEP_FETCH};
         STEP_MUL_R:    word = '{OP_MUL_R,    COND_NEVER,    STEP_FETCH};
         STEP_MUL_G:    word = '{OP_MUL_G,    COND_NEVER,    STEP_FETCH};
         STEP_MUL_B:    word = '{OP_MUL_B,    COND_NEVER,    STEP_FETCH};
         STEP_BRANCH:   word = '{OP_NOP,      COND_CLASSIFY, STEP_EMIT};
         STEP_ACCUM:    word = '{OP_ACCUM,    COND_NOT_LAST, STEP_FETCH};
         STEP_DIV_INIT: word = '{OP_DIV_INIT, COND_DIV_SKIP, STEP_FINISH};
         STEP_DIV_STEP: word = '{OP_DIV_STEP, COND_DIV_MORE, STEP_DIV_STEP};
         STEP_FINISH:   word = '{OP_FINISH,   COND_ALWAYS,   STEP_FETCH};
         STEP_EMIT:     word = '{OP_EMIT,     COND_OUT_BUSY, STEP_EMIT};
         STEP_RETURN:   word = '{OP_NOP,      COND_ALWAYS,   STEP_FETCH};
         default:       word = '{OP_NOP,      COND_ALWAYS,   STEP_FETCH};
      endcase
      return word;
   endfunction

endpackage

// ===== sv/mtb_sequencer.sv =====
// microcode sequencer: step counter, control rom lookup and jump logic
// depends on mtb_pkg
module mtb_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  mtb_pkg::stat_type stat,
   output mtb_pkg::op_type   op
);

   mtb_pkg::step_type  step_ff;
   mtb_pkg::step_type  step_in;
   mtb_pkg::ucode_type word;
   logic               taken;

   always_comb begin
      word  = mtb_pkg::ucode_rom(step_ff);
      op    = word.op;
      case (word.cond)
         mtb_pkg::COND_NEVER:    taken = 1'b0;
         mtb_pkg::COND_ALWAYS:   taken = 1'b1;
         mtb_pkg::COND_NO_REQ:   taken = !stat.req_valid;
         mtb_pkg::COND_CLASSIFY: taken = stat.classify;
         mtb_pkg::COND_NOT_LAST: taken = stat.not_last;
         mtb_pkg::COND_DIV_SKIP: taken = stat.div_skip;
         mtb_pkg::COND_DIV_MORE: taken = stat.div_more;
         mtb_pkg::COND_OUT_BUSY: taken = stat.out_busy;
         default:                taken = 1'b0;
      endcase
      step_in = taken ? word.target : step_ff + mtb_pkg::step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mtb_pkg::STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== sv/mtb_datapath.sv =====
// datapath: item latch, shared luma multiplier, sum and count, bit-serial
// divider, threshold and result register; depends on mtb_pkg and the macros
`include "mean_threshold_binarizer_macros.svh"
module mtb_datapath (
   input  logic              clock,
   input  logic              reset,
   input  mtb_pkg::op_type   op,
   input  logic              req_valid,
   input  mtb_pkg::req_type  req_item,
   input  logic              rsp_stall,
   output mtb_pkg::stat_type stat,
   output logic              rsp_valid,
   output mtb_pkg::rsp_type  rsp_item
);

   mtb_pkg::req_type                  req_ff,       req_in;
   logic [mtb_pkg::ACC_BITS-1:0]      acc_ff,       acc_in;
   logic [mtb_pkg::SUM_BITS-1:0]      sum_ff,       sum_in;
   logic [mtb_pkg::COUNT_BITS-1:0]    count_ff,     count_in;
   logic [mtb_pkg::PIX_BITS-1:0]      thr_ff,       thr_in;
   logic [mtb_pkg::DIV_BITS-1:0]      rem_ff,       rem_in;
   logic [mtb_pkg::DIV_BITS-1:0]      div_ff,       div_in;
   logic [mtb_pkg::QUO_BITS-1:0]      quo_ff,       quo_in;
   logic [mtb_pkg::BIT_BITS-1:0]      bit_ff,       bit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   mtb_pkg::rsp_type                  rsp_item_ff,  rsp_item_in;

   logic [mtb_pkg::PIX_BITS-1:0]      pix;
   logic [mtb_pkg::W_BITS-1:0]        weight;
   logic [mtb_pkg::ACC_BITS-1:0]      prod;
   logic [mtb_pkg::PIX_BITS-1:0]      luma;
   logic [mtb_pkg::SUM_BITS:0]        sum_ext;
   logic [mtb_pkg::DIV_BITS-1:0]      dividend;
   logic [mtb_pkg::DIV_BITS-1:0]      ovf_lim;
   logic                              div_zero;
   logic                              div_ovf;
   logic                              ge;
   logic                              out_busy;

   always_comb begin
      case (op)
         mtb_pkg::OP_MUL_R: begin
            pix    = req_ff.red;
            weight = mtb_pkg::W_RED;
         end
         mtb_pkg::OP_MUL_G: begin
            pix    = req_ff.green;
            weight = mtb_pkg::W_GREEN;
         end
         default: begin
            pix    = req_ff.blue;
            weight = mtb_pkg::W_BLUE;
         end
      endcase
      prod = mtb_pkg::ACC_BITS'(pix) * mtb_pkg::ACC_BITS'(weight);
   end

   assign luma     = acc_ff[mtb_pkg::LUMA_LSB +: mtb_pkg::PIX_BITS];
   assign sum_ext  = {1'b0, sum_ff} + (mtb_pkg::SUM_BITS + 1)'(luma);
   assign dividend = mtb_pkg::DIV_BITS'(sum_ff);
   assign ovf_lim  = mtb_pkg::DIV_BITS'({count_ff, mtb_pkg::QUO_BITS'(0)});
   assign div_zero = (count_ff == '0);
   assign div_ovf  = !div_zero && (dividend >= ovf_lim);
   assign ge       = (rem_ff >= div_ff);
   assign out_busy = rsp_valid_ff && rsp_stall;

   assign stat.req_valid = req_valid;
   assign stat.classify  = req_ff.action;
   assign stat.not_last  = !req_ff.last_pixel;
   assign stat.div_skip  = div_zero || div_ovf;
   assign stat.div_more  = (bit_ff != '0);
   assign stat.out_busy  = out_busy;

   always_comb begin
      req_in       = req_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      thr_in       = thr_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (op)
         mtb_pkg::OP_CAPTURE: begin
            if (req_valid) begin
               req_in = req_item;
            end
         end
         mtb_pkg::OP_MUL_R: begin
            acc_in = prod;
         end
         mtb_pkg::OP_MUL_G, mtb_pkg::OP_MUL_B: begin
            acc_in = acc_ff + prod;
         end
         mtb_pkg::OP_ACCUM: begin
            sum_in = sum_ext[mtb_pkg::SUM_BITS] ? '1 : sum_ext[mtb_pkg::SUM_BITS-1:0];
            if (count_ff != '1) begin
               count_in = count_ff + mtb_pkg::COUNT_BITS'(1);
            end
         end
         mtb_pkg::OP_DIV_INIT: begin
            rem_in = dividend;
            div_in = mtb_pkg::DIV_BITS'({count_ff, (mtb_pkg::QUO_BITS - 1)'(0)});
            quo_in = div_ovf ? '1 : '0;
            bit_in = '1;
         end
         mtb_pkg::OP_DIV_STEP: begin
            rem_in = ge ? (rem_ff - div_ff) : rem_ff;
            div_in = div_ff >> 1;
            quo_in = {quo_ff[mtb_pkg::QUO_BITS-2:0], ge};
            bit_in = bit_ff - mtb_pkg::BIT_BITS'(1);
         end
         mtb_pkg::OP_FINISH: begin
            thr_in   = quo_ff;
            sum_in   = '0;
            count_in = '0;
         end
         mtb_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_item_in.bw_pixel   = (luma > thr_ff) ? mtb_pkg::LEVEL_WHITE
                                                        : mtb_pkg::LEVEL_BLACK;
               rsp_item_in.gray_level = luma;
               rsp_item_in.last_out   = req_ff.last_pixel;
               rsp_valid_in           = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         thr_ff       <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         thr_ff       <= thr_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `MTB_ASSERT_NEXT(a_finish_clears, clock, reset, op == mtb_pkg::OP_FINISH, (sum_ff == '0) && (count_ff == '0), "sum or count not cleared after threshold latch")
   `MTB_ASSERT_NEXT(a_emit_loads, clock, reset, (op == mtb_pkg::OP_EMIT) && !out_busy, rsp_valid_ff, "emit step did not load the result register")
   `MTB_ASSERT(a_div_bound, clock, reset, (op != mtb_pkg::OP_DIV_STEP) || ((rem_ff >> 1) < div_ff), "divider remainder out of range")

endmodule

// ===== sv/mean_threshold_binarizer.sv =====
// top level of the mean threshold binarizer: sequencer plus datapath
// depends on mtb_pkg, mtb_sequencer and mtb_datapath
//
// usage
//   req channel: one pixel per item (action, red, green, blue, last_pixel)
//   rsp channel: one item per classify pixel (bw_pixel, gray_level, last_out)
//   stream the frame once with action 0 (accumulate) and last_pixel on the
//   final pixel, then again with action 1 (classify)
// sequence
//   a small microcode program runs per item over one shared 8x16 multiplier
//   accumulate item: fetch, multiply red, green and blue, branch, accumulate;
//     the last one adds divider init, a bit-serial divider for the 8-bit mean
//     at one quotient bit per cycle (skipped when the mean saturates at 255)
//     and finish; classify item: fetch to branch, then emit and return
// reset
//   sum, count and threshold go to zero, no result pending, req_stall high
// stall
//   a pending result holds in its register; the sequencer waits in the emit
//   step until it is taken, and req_stall stays high meanwhile
module mean_threshold_binarizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mtb_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mtb_pkg::rsp_type rsp_item
);

   mtb_pkg::op_type   op;
   mtb_pkg::stat_type stat;

   // control rom and step counter
   mtb_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .op    (op)
   );

   // luma, accumulation, division and result register
   mtb_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_valid (req_valid),
      .req_item  (req_item),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // items are taken only in the fetch step, never during reset
   assign req_stall = reset || (op != mtb_pkg::OP_CAPTURE);

endmodule
